// File: sv/modular_inverse_defines.svh
// ----------------------------------------------------------------------------
// Modular inverse assertion macros
// Concurrent assertion helpers for the modular inverse block.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define MI_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define MI_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define MI_ASSERT_IMP(lbl, pre, post, msg)
`define MI_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

// File: sv/modinv_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Control and status types shared by the sequencer and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package modinv_pkg;

  // Command from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: sv/modinv_div.sv
// ----------------------------------------------------------------------------
// Modular inverse radix-2 divider
// One Euclid step: restoring division that also accumulates quotient * coef.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modinv_div #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire modinv_pkg::div_ctrl_t       ctrl_i,
  input  wire logic [WORD_BITS-1:0]        dividend_i,
  input  wire logic [WORD_BITS-1:0]        divisor_i,
  input  wire logic signed [WORD_BITS+1:0] coef_i,
  output modinv_pkg::div_stat_t            stat_o,
  output logic [WORD_BITS-1:0]             rem_o,
  output logic signed [WORD_BITS+1:0]      acc_o
);

  localparam int CoefW = WORD_BITS + 2;
  localparam int CntW  = $clog2(WORD_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(WORD_BITS - 1);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [WORD_BITS-1:0]    div_q, div_d;
  logic [WORD_BITS-1:0]    dsr_q, dsr_d;
  logic signed [CoefW-1:0] cf_q, cf_d;
  logic [WORD_BITS-1:0]    rem_q, rem_d;
  logic signed [CoefW-1:0] acc_q, acc_d;

  logic [WORD_BITS:0]      trial;
  logic [WORD_BITS:0]      diff;
  logic                    ge;

  // The dividend shifts out one bit per cycle into the partial remainder.
  assign trial = {rem_q, div_q[WORD_BITS-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    dsr_d  = dsr_q;
    cf_d   = cf_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntLast;
      div_d  = dividend_i;
      dsr_d  = divisor_i;
      cf_d   = coef_i;
      rem_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      div_d = {div_q[WORD_BITS-2:0], 1'b0};
      rem_d = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      // Horner form of quotient * coef, most significant quotient bit first.
      acc_d = {acc_q[CoefW-2:0], 1'b0} + (ge ? cf_q : CoefW'(0));
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    dsr_q <= dsr_d;
    cf_q  <= cf_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;
  assign acc_o       = acc_q;

endmodule

`default_nettype wire

// File: sv/modular_inverse.sv
// ----------------------------------------------------------------------------
// Modular inverse
// Inverse of a value modulo a configured modulus by extended Euclid.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Payload
//   in        sink       in_valid_i / in_stall_o  value_i
//   out       source     out_valid_o / out_stall_i inverse_o, no_inverse_o
//   cfg       sink       cfg_we_i                 cfg_modulus_i
//
// Each Euclid step passes through the start, the divider, the wait for its done
// flag and the update; the radix-2 divider resolves one quotient bit per cycle.
// A transaction runs one step more than the Euclid steps, where the extra step
// is the initial reduction of the value. Moduli of 0 and 1 skip the divider
// and go straight to the finish state. Reset clears the sequencer and sets the
// modulus to 1. The block takes one transaction at a time; a finished result
// waits in the output register while the next transaction is already
// accepted and computed, and the sequencer holds its own result until the
// output register is free.
//
`timescale 1ns / 1ps
`default_nettype none
`include "modular_inverse_defines.svh"

module modular_inverse #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port.
  input  wire logic                 cfg_we_i,
  input  wire logic [WORD_BITS-1:0] cfg_modulus_i,
  // Input channel.
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [WORD_BITS-1:0] value_i,
  // Output channel.
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [WORD_BITS-1:0]      inverse_o,
  output logic                      no_inverse_o
);

  localparam int CoefW = WORD_BITS + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  state_e                  state_q;
  logic [WORD_BITS-1:0]    mod_q;
  // Euclid state: r0 / r1 are the remainders, c0 / c1 the Bezout coefficients
  // of the value. Coefficients stay within (-2m, 2m), hence two extra bits.
  logic [WORD_BITS-1:0]    r0_q, r1_q;
  logic signed [CoefW-1:0] c0_q, c1_q;

  logic                    out_valid_q;
  logic [WORD_BITS-1:0]    inverse_q;
  logic                    no_inverse_q;

  modinv_pkg::div_ctrl_t   div_ctrl;
  modinv_pkg::div_stat_t   div_stat;
  logic [WORD_BITS-1:0]    div_rem;
  logic signed [CoefW-1:0] div_acc;

  logic                    in_accept;
  logic                    out_take;
  logic                    out_free;
  logic signed [CoefW-1:0] lifted;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign div_ctrl.start = (state_q == ST_START);

  // Each division computes r0 / r1 and quotient * c1 at the same time.
  modinv_div #(
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (r0_q),
    .divisor_i  (r1_q),
    .coef_i     (c1_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem),
    .acc_o      (div_acc)
  );

  // A negative final coefficient is brought into range by one modulus.
  assign lifted = c0_q[CoefW-1] ? c0_q + $signed({2'b00, mod_q}) : c0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mod_q        <= WORD_BITS'(1);
      out_valid_q  <= 1'b0;
      inverse_q    <= '0;
      no_inverse_q <= 1'b0;
      r0_q         <= '0;
      r1_q         <= '0;
      c0_q         <= '0;
      c1_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_modulus_i;
      end
      // In the finish state a taken result is replaced by the new one below.
      if (out_take && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (mod_q > WORD_BITS'(1)) begin
              // The first step, value / modulus with coefficients (1, 0), is
              // the reduction; it leaves r0 = m, r1 = value mod m, c = (0, 1).
              r0_q    <= value_i;
              r1_q    <= mod_q;
              c0_q    <= CoefW'(1);
              c1_q    <= '0;
              state_q <= ST_START;
            end else begin
              // Modulus of one gives inverse 0; modulus of zero has none.
              r0_q    <= mod_q;
              c0_q    <= '0;
              state_q <= ST_FINISH;
            end
          end
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          r0_q <= r1_q;
          r1_q <= div_rem;
          c0_q <= c1_q;
          c1_q <= c0_q - div_acc;
          state_q <= (div_rem == '0) ? ST_FINISH : ST_START;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (r0_q == WORD_BITS'(1)) begin
              inverse_q    <= lifted[WORD_BITS-1:0];
              no_inverse_q <= 1'b0;
            end else begin
              inverse_q    <= '0;
              no_inverse_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign inverse_o    = inverse_q;
  assign no_inverse_o = no_inverse_q;

  // The sequencer must never take a new transaction while the divider runs.
  `MI_ASSERT_IMP(a_div_busy_stalls, div_stat.busy, in_stall_o, "divider busy while idle")
  // An accepted transaction always occupies the sequencer on the next cycle.
  `MI_ASSERT_NXT(a_accept_busy, in_accept, in_stall_o, "accept did not start work")
  // A missing inverse is always reported as zero.
  `MI_ASSERT_IMP(a_none_zero, out_valid_o && no_inverse_o, inverse_o == '0,
                 "no-inverse result is not zero")
  // A valid inverse lies below the modulus.
  `MI_ASSERT_IMP(a_inv_range, out_valid_o && !no_inverse_o, inverse_o < mod_q,
                 "inverse not reduced")

endmodule

`default_nettype wire
